/* src/tlbpt_pkg.sv */
// ----------------------------------------------------------------------------
// tlbpt_pkg: shared types and constants for the translation block
// Holds the page geometry, the default table sizes and the TLB command.
// ----------------------------------------------------------------------------
package tlbpt_pkg;

	localparam int PAGE_W      = 8;
	localparam int OFFSET_W    = 8;
	localparam int VA_W        = PAGE_W + OFFSET_W;
	localparam int CNT_W       = 16;
	localparam int TLB_DEFAULT = 16;
	localparam int PT_DEFAULT  = 256;

	typedef struct packed {
		logic                touch;
		logic                insert;
		logic [PAGE_W-1:0]   frame;
	} tlb_cmd_t;

endpackage

/* src/tlb_page_table_lru_translate_top.sv */
// ----------------------------------------------------------------------------
// tlb_page_table_lru_translate_top: TLB and page table address translation
// Channel  Direction  Beat
// in       input      virtual_address
// out      output     physical_address, tlb_hit, page_fault, totals
// A TLB hit goes from accept through the TLB state to FIN. A TLB miss walks the page
// table RAM over its valid entries, and a hit or a full-table eviction
// then sweeps the RAM again to update LRU ranks.
// Reset clears all fill counts and counters; no clearing pass is needed.
// A result waiting under stall holds the sequencer in its final state.
// ----------------------------------------------------------------------------
module tlb_page_table_lru_translate_top
	import tlbpt_pkg::*;
#(
	parameter int TLB_ENTRIES = TLB_DEFAULT,
	parameter int PT_ENTRIES  = PT_DEFAULT
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [VA_W-1:0]     virtual_address,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [VA_W-1:0]     physical_address,
	output logic                tlb_hit,
	output logic                page_fault,
	output logic [CNT_W-1:0]    tlb_hit_total,
	output logic [CNT_W-1:0]    fault_total
);

	localparam int AW = (PT_ENTRIES > 1) ? $clog2(PT_ENTRIES) : 1;
	localparam int FW = $clog2(PT_ENTRIES + 1);
	localparam int DW = 2 * PAGE_W + AW;

	typedef enum logic [2:0] {
		IDLE, TLB, PT_RD, PT_CMP, PT_FAULT, SW_RD, SW_WR, FIN
	} state_t;

	state_t            state_q;
	logic [VA_W-1:0]   va_q;
	logic [AW-1:0]     idx_q;
	logic [AW-1:0]     slot_q;
	logic [AW-1:0]     victim_q;
	logic [AW-1:0]     r_q;
	logic              ins_q;
	logic [PAGE_W-1:0] frame_q;
	logic [PAGE_W-1:0] nff_q;
	logic [FW-1:0]     ptfill_q;
	logic              hit_q;
	logic              fault_q;
	logic [CNT_W-1:0]  hitcnt_q;
	logic [CNT_W-1:0]  faultcnt_q;

	logic [PAGE_W-1:0] page;
	logic              t_hit;
	logic [PAGE_W-1:0] t_frame;
	tlb_cmd_t          tcmd;
	logic              we;
	logic [AW-1:0]     waddr;
	logic [DW-1:0]     wdata;
	logic [DW-1:0]     rdata;
	logic [PAGE_W-1:0] rd_tag;
	logic [PAGE_W-1:0] rd_frm;
	logic [AW-1:0]     rd_rank;
	logic              last;
	logic [AW-1:0]     top_rank;
	logic              pt_full;

	assign page     = va_q[VA_W-1 -: PAGE_W];
	assign rd_tag   = rdata[DW-1 -: PAGE_W];
	assign rd_frm   = rdata[AW +: PAGE_W];
	assign rd_rank  = rdata[AW-1:0];
	assign last     = (FW'(idx_q) == ptfill_q - FW'(1));
	assign top_rank = AW'(ptfill_q - FW'(1));
	assign pt_full  = (ptfill_q == FW'(PT_ENTRIES));
	assign in_stall = (state_q != IDLE);

	always_comb begin
		tcmd.touch  = (state_q == TLB) && t_hit;
		tcmd.insert = (state_q == PT_FAULT);
		tcmd.frame  = nff_q;
	end

	always_comb begin
		we    = 1'b0;
		waddr = idx_q;
		wdata = rdata;
		if (state_q == PT_FAULT && !pt_full) begin
			we    = 1'b1;
			waddr = AW'(ptfill_q);
			wdata = {page, nff_q, AW'(ptfill_q)};
		end else if (state_q == SW_WR) begin
			we = 1'b1;
			if (idx_q == slot_q) begin
				wdata = {(ins_q ? page : rd_tag), (ins_q ? frame_q : rd_frm), top_rank};
			end else if (rd_rank > r_q) begin
				wdata = {rd_tag, rd_frm, rd_rank - AW'(1)};
			end
		end
	end

	tlbpt_tlb #(
		.TLB_ENTRIES(TLB_ENTRIES)
	) u_tlb (
		.clk       (clk),
		.arst_n    (arst_n),
		.page      (page),
		.cmd       (tcmd),
		.hit       (t_hit),
		.hit_frame (t_frame)
	);

	tlbpt_ram #(
		.WIDTH(DW),
		.DEPTH(PT_ENTRIES),
		.AW   (AW)
	) u_pt_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (idx_q),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q          <= IDLE;
			va_q             <= '0;
			idx_q            <= '0;
			slot_q           <= '0;
			victim_q         <= '0;
			r_q              <= '0;
			ins_q            <= 1'b0;
			frame_q          <= '0;
			nff_q            <= '0;
			ptfill_q         <= '0;
			hit_q            <= 1'b0;
			fault_q          <= 1'b0;
			hitcnt_q         <= '0;
			faultcnt_q       <= '0;
			out_valid        <= 1'b0;
			physical_address <= '0;
			tlb_hit          <= 1'b0;
			page_fault       <= 1'b0;
			tlb_hit_total    <= '0;
			fault_total      <= '0;
		end else begin
			if (out_valid && !out_stall && state_q != FIN) begin
				out_valid <= 1'b0;
			end
			unique case (state_q)
				IDLE: begin
					if (in_valid) begin
						va_q    <= virtual_address;
						state_q <= TLB;
					end
				end
				TLB: begin
					idx_q <= '0;
					if (t_hit) begin
						frame_q  <= t_frame;
						hit_q    <= 1'b1;
						fault_q  <= 1'b0;
						hitcnt_q <= hitcnt_q + CNT_W'(1);
						state_q  <= FIN;
					end else if (ptfill_q == '0) begin
						state_q <= PT_FAULT;
					end else begin
						state_q <= PT_RD;
					end
				end
				PT_RD: begin
					state_q <= PT_CMP;
				end
				PT_CMP: begin
					if (rd_tag == page) begin
						slot_q  <= idx_q;
						r_q     <= rd_rank;
						frame_q <= rd_frm;
						ins_q   <= 1'b0;
						hit_q   <= 1'b0;
						fault_q <= 1'b0;
						idx_q   <= '0;
						state_q <= SW_RD;
					end else begin
						if (rd_rank == '0) begin
							victim_q <= idx_q;
						end
						if (last) begin
							state_q <= PT_FAULT;
						end else begin
							idx_q   <= idx_q + AW'(1);
							state_q <= PT_RD;
						end
					end
				end
				PT_FAULT: begin
					frame_q    <= nff_q;
					nff_q      <= nff_q + PAGE_W'(1);
					faultcnt_q <= faultcnt_q + CNT_W'(1);
					hit_q      <= 1'b0;
					fault_q    <= 1'b1;
					if (pt_full) begin
						slot_q  <= victim_q;
						r_q     <= '0;
						ins_q   <= 1'b1;
						idx_q   <= '0;
						state_q <= SW_RD;
					end else begin
						ptfill_q <= ptfill_q + FW'(1);
						state_q  <= FIN;
					end
				end
				SW_RD: begin
					state_q <= SW_WR;
				end
				SW_WR: begin
					if (last) begin
						state_q <= FIN;
					end else begin
						idx_q   <= idx_q + AW'(1);
						state_q <= SW_RD;
					end
				end
				FIN: begin
					if (!out_valid || !out_stall) begin
						out_valid        <= 1'b1;
						physical_address <= {frame_q, va_q[OFFSET_W-1:0]};
						tlb_hit          <= hit_q;
						page_fault       <= fault_q;
						tlb_hit_total    <= hitcnt_q;
						fault_total      <= faultcnt_q;
						state_q          <= IDLE;
					end
				end
				default: begin
					state_q <= IDLE;
				end
			endcase
		end
	end

	a_fill_cap: assert property (@(posedge clk) disable iff (!arst_n)
		ptfill_q <= FW'(PT_ENTRIES))
		else $error("page table fill count above capacity");

	a_flags_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(tlb_hit && page_fault))
		else $error("result beat flags both a TLB hit and a page fault");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("input beat accepted while sequencer stays idle");

	a_fault_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == PT_FAULT) |=> (faultcnt_q == $past(faultcnt_q) + CNT_W'(1)))
		else $error("page fault did not advance the fault count");

endmodule

/* src/tlbpt_ram.sv */
// ----------------------------------------------------------------------------
// tlbpt_ram: generic single-clock RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module tlbpt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

/* src/tlbpt_tlb.sv */
// ----------------------------------------------------------------------------
// tlbpt_tlb: fully associative TLB with true LRU ranks
// Parallel tag compare; every slot keeps its recency rank, 0 being least
// recently used. Touch and insert update all affected ranks at once.
// ----------------------------------------------------------------------------
module tlbpt_tlb
	import tlbpt_pkg::*;
#(
	parameter int TLB_ENTRIES = TLB_DEFAULT
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [PAGE_W-1:0] page,
	input  tlb_cmd_t          cmd,
	output logic              hit,
	output logic [PAGE_W-1:0] hit_frame
);

	localparam int TAW = (TLB_ENTRIES > 1) ? $clog2(TLB_ENTRIES) : 1;
	localparam int TFW = $clog2(TLB_ENTRIES + 1);

	logic [PAGE_W-1:0] tag_q  [TLB_ENTRIES];
	logic [PAGE_W-1:0] frm_q  [TLB_ENTRIES];
	logic [TAW-1:0]    rank_q [TLB_ENTRIES];
	logic [TFW-1:0]    fill_q;
	logic [TAW-1:0]    slot;
	logic [TAW-1:0]    victim;
	logic              full;
	logic [TAW-1:0]    top_rank;

	assign full     = (fill_q == TFW'(TLB_ENTRIES));
	assign top_rank = TAW'(fill_q - TFW'(1));

	always_comb begin
		hit    = 1'b0;
		slot   = '0;
		victim = '0;
		for (int i = 0; i < TLB_ENTRIES; i++) begin
			if (i < int'(fill_q) && tag_q[i] == page && !hit) begin
				hit  = 1'b1;
				slot = TAW'(i);
			end
			if (i < int'(fill_q) && rank_q[i] == '0) begin
				victim = TAW'(i);
			end
		end
		hit_frame = frm_q[slot];
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < TLB_ENTRIES; i++) begin
			if (cmd.touch && hit) begin
				if (TAW'(i) == slot) begin
					rank_q[i] <= top_rank;
				end else if (rank_q[i] > rank_q[slot]) begin
					rank_q[i] <= rank_q[i] - TAW'(1);
				end
			end else if (cmd.insert) begin
				if (full) begin
					if (TAW'(i) == victim) begin
						tag_q[i]  <= page;
						frm_q[i]  <= cmd.frame;
						rank_q[i] <= TAW'(TLB_ENTRIES - 1);
					end else begin
						rank_q[i] <= rank_q[i] - TAW'(1);
					end
				end else if (i == int'(fill_q)) begin
					tag_q[i]  <= page;
					frm_q[i]  <= cmd.frame;
					rank_q[i] <= TAW'(fill_q);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (cmd.insert && !full) begin
			fill_q <= fill_q + TFW'(1);
		end
	end

endmodule

/* tb/tb.sv */
// ----------------------------------------------------------------------------
// tb: self-checking bench for tlb_page_table_lru_translate_top
// Drives virtual addresses with bursty valid, stalls the result side on its
// own pattern, and checks each result beat against typed expectations or
// a bench TLB/page-table model with true LRU replacement and demand paging.
// ----------------------------------------------------------------------------
module tb;
	import tlbpt_pkg::*;

	localparam int TLB_N      = TLB_DEFAULT;
	localparam int PT_N       = PT_DEFAULT;
	localparam int N_RANDOM   = 1000;
	localparam int CYCLE_CAP  = 6000000;
	localparam int DRAIN_WAIT = 2000;

	typedef struct {
		logic [VA_W-1:0]  pa;
		logic             hit;
		logic             fault;
		logic [CNT_W-1:0] hits;
		logic [CNT_W-1:0] faults;
	} xlate_t;

	typedef struct {
		logic [VA_W-1:0] va;
		bit              typed;
		xlate_t          res;
	} stim_row_t;

	logic             clk;
	logic             arst_n;
	logic             in_valid;
	logic             in_stall;
	logic [VA_W-1:0]  virtual_address;
	logic             out_valid;
	logic             out_stall;
	logic [VA_W-1:0]  physical_address;
	logic             tlb_hit;
	logic             page_fault;
	logic [CNT_W-1:0] tlb_hit_total;
	logic [CNT_W-1:0] fault_total;

	logic [PAGE_W-1:0] tlb_tag [TLB_N];
	logic [PAGE_W-1:0] tlb_frm [TLB_N];
	int                tlb_ord [TLB_N];
	int                tlb_cnt;
	logic [PAGE_W-1:0] pt_tag [PT_N];
	logic [PAGE_W-1:0] pt_frm [PT_N];
	int                pt_ord [PT_N];
	int                pt_cnt;
	logic [PAGE_W-1:0] free_frame;
	logic [CNT_W-1:0]  hit_count;
	logic [CNT_W-1:0]  fault_count;

	xlate_t    pending_xlates[$];
	stim_row_t directed[$];
	int        errors;
	longint    cycles;

	tlb_page_table_lru_translate_top #(
		.TLB_ENTRIES(TLB_N),
		.PT_ENTRIES (PT_N)
	) i_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.virtual_address (virtual_address),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.physical_address(physical_address),
		.tlb_hit         (tlb_hit),
		.page_fault      (page_fault),
		.tlb_hit_total   (tlb_hit_total),
		.fault_total     (fault_total)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	task automatic report_mismatch(string field, longint got, longint want);
		$display("mismatch on %s: got %0h, expected %0h", field, got, want);
		errors++;
	endtask

	// Moves slot to the most recently used end of an order list.
	task automatic promote(ref int ord[], input int cnt, input int slot);
		int pos;
		pos = cnt;
		for (int i = 0; i < cnt; i++) begin
			if (ord[i] == slot && pos == cnt) begin
				pos = i;
			end
		end
		if (pos < cnt) begin
			for (int i = pos; i + 1 < cnt; i++) begin
				ord[i] = ord[i + 1];
			end
			ord[cnt - 1] = slot;
		end
	endtask

	task automatic translate(input logic [VA_W-1:0] va, output xlate_t r);
		logic [PAGE_W-1:0] page;
		logic [PAGE_W-1:0] frame;
		int slot;
		int t_ord[];
		int p_ord[];
		page = va[VA_W-1:OFFSET_W];
		t_ord = new[TLB_N];
		p_ord = new[PT_N];
		foreach (tlb_ord[i]) t_ord[i] = tlb_ord[i];
		foreach (pt_ord[i]) p_ord[i] = pt_ord[i];
		r.hit = 1'b0;
		r.fault = 1'b0;
		slot = -1;
		for (int i = 0; i < tlb_cnt; i++) begin
			if (slot < 0 && tlb_tag[i] == page) slot = i;
		end
		if (slot >= 0) begin
			r.hit = 1'b1;
			hit_count++;
			frame = tlb_frm[slot];
			promote(t_ord, tlb_cnt, slot);
		end else begin
			for (int i = 0; i < pt_cnt; i++) begin
				if (slot < 0 && pt_tag[i] == page) slot = i;
			end
			if (slot >= 0) begin
				frame = pt_frm[slot];
				promote(p_ord, pt_cnt, slot);
			end else begin
				r.fault = 1'b1;
				fault_count++;
				frame = free_frame;
				free_frame++;
				if (pt_cnt >= PT_N) begin
					slot = p_ord[0];
					for (int i = 0; i + 1 < PT_N; i++) p_ord[i] = p_ord[i + 1];
					pt_cnt = PT_N - 1;
				end else begin
					slot = pt_cnt;
				end
				pt_tag[slot] = page;
				pt_frm[slot] = frame;
				p_ord[pt_cnt] = slot;
				pt_cnt++;
				if (tlb_cnt >= TLB_N) begin
					slot = t_ord[0];
					for (int i = 0; i + 1 < TLB_N; i++) t_ord[i] = t_ord[i + 1];
					tlb_cnt = TLB_N - 1;
				end else begin
					slot = tlb_cnt;
				end
				tlb_tag[slot] = page;
				tlb_frm[slot] = frame;
				t_ord[tlb_cnt] = slot;
				tlb_cnt++;
			end
		end
		foreach (tlb_ord[i]) tlb_ord[i] = t_ord[i];
		foreach (pt_ord[i]) pt_ord[i] = p_ord[i];
		r.pa = {frame, va[OFFSET_W-1:0]};
		r.hits = hit_count;
		r.faults = fault_count;
	endtask

	task automatic add_row(input logic [VA_W-1:0] va, input bit typed,
			input logic [VA_W-1:0] pa = '0, input logic hit = 1'b0,
			input logic fault = 1'b0, input int hits = 0, input int faults = 0);
		stim_row_t row;
		row.va = va;
		row.typed = typed;
		row.res.pa = pa;
		row.res.hit = hit;
		row.res.fault = fault;
		row.res.hits = CNT_W'(hits);
		row.res.faults = CNT_W'(faults);
		directed.push_back(row);
	endtask

	task automatic send_beat(input logic [VA_W-1:0] va, input bit typed,
			input xlate_t typed_res);
		xlate_t r;
		in_valid <= 1'b1;
		virtual_address <= va;
		do @(posedge clk); while (in_stall);
		translate(va, r);
		pending_xlates.push_back(typed ? typed_res : r);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			case ((cycles / 97) % 4)
				0: out_stall <= 1'b0;
				1: out_stall <= ($urandom_range(0, 1) == 0);
				2: out_stall <= ($urandom_range(0, 9) < 8);
				default: out_stall <= ($urandom_range(0, 9) == 0);
			endcase
		end
	end

	always @(posedge clk) begin
		xlate_t e;
		cycles++;
		if (cycles > CYCLE_CAP) begin
			$display("Verification failed");
			$finish;
		end
		if (arst_n && out_valid && !out_stall) begin
			if (pending_xlates.size() == 0) begin
				report_mismatch("unexpected result beat", 1, 0);
			end else begin
				e = pending_xlates.pop_front();
				if (physical_address !== e.pa)
					report_mismatch("physical_address", physical_address, e.pa);
				if (tlb_hit !== e.hit) report_mismatch("tlb_hit", tlb_hit, e.hit);
				if (page_fault !== e.fault)
					report_mismatch("page_fault", page_fault, e.fault);
				if (tlb_hit_total !== e.hits)
					report_mismatch("tlb_hit_total", tlb_hit_total, e.hits);
				if (fault_total !== e.faults)
					report_mismatch("fault_total", fault_total, e.faults);
			end
		end
	end

	initial begin
		xlate_t none;
		int burst;
		int gap;
		int base;
		int wait_cycles;
		logic [PAGE_W-1:0] page;
		errors = 0;
		cycles = 0;
		tlb_cnt = 0;
		pt_cnt = 0;
		free_frame = '0;
		hit_count = '0;
		fault_count = '0;
		foreach (tlb_ord[i]) tlb_ord[i] = 0;
		foreach (pt_ord[i]) pt_ord[i] = 0;
		none = '{default: '0};
		arst_n = 1'b0;
		in_valid = 1'b0;
		virtual_address = '0;

		// Extremes first, then enough new pages to push the first pages out of
		// the TLB so that they come back as page-table hits.
		add_row(16'h0000, 1'b1, 16'h0000, 1'b0, 1'b1, 0, 1);
		add_row(16'h00FF, 1'b1, 16'h00FF, 1'b1, 1'b0, 1, 1);
		add_row(16'hFFFF, 1'b1, 16'h01FF, 1'b0, 1'b1, 1, 2);
		add_row(16'hAA55, 1'b1, 16'h0255, 1'b0, 1'b1, 1, 3);
		add_row(16'hFF00, 1'b1, 16'h0100, 1'b1, 1'b0, 2, 3);
		for (int p = 1; p <= 16; p++) add_row({p[7:0], p[7:0] ^ 8'hA5}, 1'b0);
		add_row(16'h0012, 1'b0);
		add_row(16'hAAC3, 1'b0);
		add_row(16'h0034, 1'b0);
		add_row(16'h1080, 1'b0);

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i]) send_beat(directed[i].va, directed[i].typed, directed[i].res);
		in_valid <= 1'b0;
		@(posedge clk);

		burst = 0;
		for (int n = 0; n < N_RANDOM; n++) begin
			if (burst == 0 && n >= 150) begin
				burst = $urandom_range(1, 20);
				gap = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 30)
					: $urandom_range(0, 4);
				if (gap > 0) begin
					in_valid <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
			if (burst > 0) burst--;
			// A sliding working set reaches every page and wraps the frames,
			// while revisits give TLB hits and page-table hits.
			base = n / 3;
			case ($urandom_range(0, 9))
				0, 1: page = PAGE_W'($urandom_range(0, 255));
				2, 3: page = PAGE_W'(base + $urandom_range(0, 40));
				default: page = PAGE_W'(base + $urandom_range(0, 14));
			endcase
			send_beat({page, 8'($urandom_range(0, 255))}, 1'b0, none);
		end
		in_valid <= 1'b0;

		wait_cycles = 0;
		while (pending_xlates.size() != 0 && wait_cycles < CYCLE_CAP) begin
			@(posedge clk);
			wait_cycles++;
		end
		repeat (DRAIN_WAIT) @(posedge clk);
		if (errors == 0 && pending_xlates.size() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule

/* tlb_page_table_lru_translate_top.f */
src/tlbpt_pkg.sv
src/tlbpt_ram.sv
src/tlbpt_tlb.sv
src/tlb_page_table_lru_translate_top.sv
tb/tb.sv
